[rtl/wllo_pkg.sv]
package wllo_pkg;

   // Input sample width in bits, two's complement (8 to 32)
   localparam int SAMPLE_WIDTH = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEVEL    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERLAY_ENABLE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERLAY_OPACITY = 2'd3;
   localparam int CSR_DATA_W = 16;

   localparam int LEVEL_W   = 16;
   localparam int WIDTH_W   = 16;
   localparam int OPACITY_W = 9;
   localparam int CHAN_W    = 8;
   localparam int LABEL_W   = 8;

   // Full-scale opacity in Q8
   localparam logic [OPACITY_W-1:0] OPACITY_FULL = 9'd256;

   // Window arithmetic widths
   localparam int VAL_W = (SAMPLE_WIDTH > LEVEL_W) ? SAMPLE_WIDTH : LEVEL_W;
   localparam int N_W   = VAL_W + 3;          // 2*(v-L)+W, signed
   localparam int DEN_W = WIDTH_W + 1;        // 2*W
   localparam int QUO_W = CHAN_W;             // gray quotient bits
   localparam int NUM_W = DEN_W + QUO_W;      // 255*n + W < 256*2W

   // Overlay color: red, green, blue
   localparam int NUM_CHAN = 3;
   localparam logic [CHAN_W-1:0] OVERLAY_COLOR [NUM_CHAN] = '{8'd236, 8'd72, 8'd153};

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_value;
      logic [LABEL_W-1:0]             label_value;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rsp_type;

   // Per-pixel flags that ride along the divider
   typedef struct packed {
      logic labelled;
      logic sat_lo;
      logic sat_hi;
   } wllo_side_type;

   // One beat in the divider pipeline
   typedef struct packed {
      logic             valid;
      wllo_side_type    side;
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } wllo_div_beat_type;

endpackage

[rtl/wllo_window.sv]
module wllo_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  wllo_pkg::req_type                in_data,
   input  logic signed [wllo_pkg::LEVEL_W-1:0] window_level,
   input  logic [wllo_pkg::WIDTH_W-1:0]     width_eff,
   output wllo_pkg::wllo_div_beat_type      out_beat
);
   import wllo_pkg::*;

   logic                    valid1_ff;
   logic signed [N_W-1:0]   n_ff, n_in;
   logic                    labelled_ff;
   logic signed [N_W-1:0]   v_ext, level_ext, width_ext, width2_ext;
   logic [DEN_W-1:0]        n_low;
   wllo_div_beat_type       beat_ff, beat_in;

   // Stage 1: offset the sample into n = 2*(v-L) + W
   always_comb begin
      v_ext     = N_W'(in_data.sample_value);
      level_ext = N_W'(window_level);
      width_ext = N_W'(signed'({1'b0, width_eff}));
      n_in      = ((v_ext - level_ext) <<< 1) + width_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      n_ff        <= n_in;
      labelled_ff <= (in_data.label_value != '0);
   end

   // Stage 2: classify against the window and form the dividend 255*n + W
   always_comb begin
      width2_ext           = N_W'(signed'({1'b0, width_eff, 1'b0}));
      n_low                = n_ff[DEN_W-1:0];
      beat_in.valid        = valid1_ff;
      beat_in.side.labelled = labelled_ff;
      beat_in.side.sat_lo  = n_ff[N_W-1] || (n_ff == '0);
      beat_in.side.sat_hi  = (n_ff >= width2_ext);
      beat_in.rem          = {n_low, {QUO_W{1'b0}}} - NUM_W'(n_low) + NUM_W'(width_eff);
      beat_in.quo          = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.side <= beat_in.side;
      beat_ff.rem  <= beat_in.rem;
      beat_ff.quo  <= beat_in.quo;
   end

   assign out_beat = beat_ff;

endmodule

[rtl/wllo_div_stage.sv]
module wllo_div_stage #(
   parameter int SHIFT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wllo_pkg::DEN_W-1:0]    den,
   input  wllo_pkg::wllo_div_beat_type   in_beat,
   output wllo_pkg::wllo_div_beat_type   out_beat
);
   import wllo_pkg::*;

   logic [NUM_W-1:0]  trial;
   wllo_div_beat_type beat_ff, beat_in;

   // Resolve one quotient bit: subtract the shifted divisor if it fits
   always_comb begin
      trial   = NUM_W'(den) << SHIFT;
      beat_in = in_beat;
      if (in_beat.rem >= trial) begin
         beat_in.rem        = in_beat.rem - trial;
         beat_in.quo[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.side <= beat_in.side;
      beat_ff.rem  <= beat_in.rem;
      beat_ff.quo  <= beat_in.quo;
   end

   assign out_beat = beat_ff;

endmodule

[rtl/wllo_blend.sv]
module wllo_blend (
   input  logic                             clock,
   input  logic                             reset,
   input  wllo_pkg::wllo_div_beat_type      in_beat,
   input  logic                             overlay_enable,
   input  logic [wllo_pkg::OPACITY_W-1:0]   opacity_eff,
   output logic                             out_valid,
   output wllo_pkg::rsp_type                out_data
);
   import wllo_pkg::*;

   localparam int PROD_W = CHAN_W + OPACITY_W;

   logic                  valid_a_ff, valid_b_ff, valid_c_ff;
   logic [CHAN_W-1:0]     gray_ff, gray_in;
   logic                  blend_a_ff;
   logic [CHAN_W-1:0]     gray_b_ff;
   logic                  blend_b_ff;
   logic [PROD_W-1:0]     gray_prod_ff, gray_prod_in;
   logic [PROD_W-1:0]     color_prod_ff [NUM_CHAN];
   logic [PROD_W-1:0]     color_prod_in [NUM_CHAN];
   logic [CHAN_W-1:0]     chan_in [NUM_CHAN];
   logic [PROD_W-1:0]     sum [NUM_CHAN];
   logic [OPACITY_W-1:0]  keep;
   rsp_type               data_ff;

   // Stage A: clamp to the window limits
   always_comb begin
      if (in_beat.side.sat_hi) begin
         gray_in = '1;
      end else if (in_beat.side.sat_lo) begin
         gray_in = '0;
      end else begin
         gray_in = in_beat.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_beat.valid;
      end
      gray_ff    <= gray_in;
      blend_a_ff <= in_beat.side.labelled & overlay_enable;
   end

   // Stage B: weight gray and overlay color by opacity
   always_comb begin
      keep         = OPACITY_FULL - opacity_eff;
      gray_prod_in = PROD_W'(gray_ff) * PROD_W'(keep);
      for (int c = 0; c < NUM_CHAN; c++) begin
         color_prod_in[c] = PROD_W'(OVERLAY_COLOR[c]) * PROD_W'(opacity_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      gray_b_ff    <= gray_ff;
      blend_b_ff   <= blend_a_ff;
      gray_prod_ff <= gray_prod_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
         color_prod_ff[c] <= color_prod_in[c];
      end
   end

   // Stage C: sum, round half up, drop to eight bits; unblended pixels keep the gray
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum[c] = gray_prod_ff + color_prod_ff[c] + PROD_W'(128);
         if (blend_b_ff) begin
            chan_in[c] = sum[c][CHAN_W +: CHAN_W];
         end else begin
            chan_in[c] = gray_b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
      data_ff.red   <= chan_in[0];
      data_ff.green <= chan_in[1];
      data_ff.blue  <= chan_in[2];
   end

   assign out_valid = valid_c_ff;
   assign out_data  = data_ff;

endmodule

[rtl/window_level_label_overlay.sv]
// Window/level gray shading with a label color overlay. One pixel is taken
// on every clock that start is high and busy is low; busy is a register that
// reset sets and that clears once reset is released. Each pixel returns as one rsp_valid beat,
// in order, at a sustained rate of one pixel per clock, after two window stages,
// eight restoring-divide stages (one gray bit each) and three blend stages.
// rsp_valid is a one-cycle strobe the receiver cannot hold off. Write the csr_
// registers only with no pixel in flight.
module window_level_label_overlay (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  wllo_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output wllo_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [wllo_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wllo_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wllo_pkg::*;

   logic                        busy_ff;
   logic signed [LEVEL_W-1:0]   window_level_ff;
   logic [WIDTH_W-1:0]          window_width_ff;
   logic                        overlay_enable_ff;
   logic [OPACITY_W-1:0]        overlay_opacity_ff;
   logic [WIDTH_W-1:0]          width_eff;
   logic [DEN_W-1:0]            den;
   logic [OPACITY_W-1:0]        opacity_eff;
   wllo_div_beat_type           div_beat [QUO_W+1];

   // Hold off the first cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_level_ff    <= 16'sd40;
         window_width_ff    <= 16'd400;
         overlay_enable_ff  <= 1'b1;
         overlay_opacity_ff <= 9'd128;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LEVEL:    window_level_ff    <= signed'(csr_wdata[LEVEL_W-1:0]);
            CSR_WINDOW_WIDTH:    window_width_ff    <= csr_wdata[WIDTH_W-1:0];
            CSR_OVERLAY_ENABLE:  overlay_enable_ff  <= csr_wdata[0];
            CSR_OVERLAY_OPACITY: overlay_opacity_ff <= csr_wdata[OPACITY_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero width acts as one; opacity saturates at fully opaque
   always_comb begin
      width_eff   = (window_width_ff == '0) ? WIDTH_W'(1) : window_width_ff;
      den         = {width_eff, 1'b0};
      opacity_eff = (overlay_opacity_ff > OPACITY_FULL) ? OPACITY_FULL : overlay_opacity_ff;
   end

   wllo_window u_window (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start & ~busy_ff),
      .in_data      (req_data),
      .window_level (window_level_ff),
      .width_eff    (width_eff),
      .out_beat     (div_beat[0])
   );

   // Divider chain, most significant quotient bit first
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      wllo_div_stage #(
         .SHIFT (QUO_W - 1 - k)
      ) u_div_stage (
         .clock    (clock),
         .reset    (reset),
         .den      (den),
         .in_beat  (div_beat[k]),
         .out_beat (div_beat[k+1])
      );
   end

   wllo_blend u_blend (
      .clock          (clock),
      .reset          (reset),
      .in_beat        (div_beat[QUO_W]),
      .overlay_enable (overlay_enable_ff),
      .opacity_eff    (opacity_eff),
      .out_valid      (rsp_valid),
      .out_data       (rsp_data)
   );

endmodule

[tb/sv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wllo_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 20;      // pipeline is 13 deep, leave margin
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_PIXELS  = 50;

   // Fixed overlay color
   localparam int OVL_RED   = 236;
   localparam int OVL_GREEN = 72;
   localparam int OVL_BLUE  = 153;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_WINDOW_LEVEL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow copy of the window and overlay registers
   logic signed [LEVEL_W-1:0] cfg_level   = 16'sd40;
   logic [WIDTH_W-1:0]        cfg_width   = 16'd400;
   logic                      cfg_enable  = 1'b1;
   logic [OPACITY_W-1:0]      cfg_opacity = 9'd128;

   rsp_type pending_pixels[$];
   int      errors = 0;
   int      pixels_sent = 0;
   int      pixels_checked = 0;
   int      pixels_tinted = 0;
   int      settings_used = 1;
   int      cycle_count = 0;

   window_level_label_overlay dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Blend one gray channel toward an overlay color channel, round half up
   function automatic logic [CHAN_W-1:0] mix_channel(input int g, input int k, input int a);
      int t;
      t = (g * (256 - a) + k * a + 128) >> 8;
      return t[CHAN_W-1:0];
   endfunction

   // Window-level the sample to gray, then tint labelled pixels
   function automatic rsp_type shade_pixel(input req_type px);
      longint  v;
      longint  w;
      longint  n;
      int      g;
      int      a;
      rsp_type shaded;
      v = longint'($signed(px.sample_value));
      w = (cfg_width == '0) ? 64'sd1 : longint'(cfg_width);
      n = 2 * (v - longint'(cfg_level)) + w;
      if (n <= 0)
         g = 0;
      else if (n >= 2 * w)
         g = 255;
      else
         g = int'((255 * n + w) / (2 * w));
      a = (cfg_opacity > OPACITY_FULL) ? 256 : int'(cfg_opacity);
      if (cfg_enable && px.label_value != '0) begin
         shaded.red   = mix_channel(g, OVL_RED, a);
         shaded.green = mix_channel(g, OVL_GREEN, a);
         shaded.blue  = mix_channel(g, OVL_BLUE, a);
      end else begin
         shaded.red   = g[CHAN_W-1:0];
         shaded.green = g[CHAN_W-1:0];
         shaded.blue  = g[CHAN_W-1:0];
      end
      return shaded;
   endfunction

   function automatic req_type pixel(input int v, input int lbl);
      req_type px;
      px.sample_value = v[SAMPLE_WIDTH-1:0];
      px.label_value  = lbl[LABEL_W-1:0];
      return px;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Bias samples toward the current window so the ramp is well exercised
   function automatic req_type random_pixel();
      req_type px;
      longint  v;
      longint  span;
      int      r;
      r = $urandom_range(0, 99);
      span = longint'(cfg_width) + 8;
      if (r < 60)
         v = longint'(cfg_level) + longint'($urandom_range(0, int'(span))) - span / 2;
      else if (r < 85)
         v = longint'($urandom_range(0, 65535));
      else begin
         case ($urandom_range(0, 3))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            default: v = -1;
         endcase
      end
      px.sample_value = v[SAMPLE_WIDTH-1:0];
      if ($urandom_range(0, 9) < 4)
         px.label_value = '0;
      else
         px.label_value = LABEL_W'($urandom_range(1, 255));
      return px;
   endfunction

   // Present one pixel and hold it until the block takes it; start stays high
   task automatic send_pixel(input req_type px);
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(shade_pixel(px));
      pixels_sent++;
      if (cfg_enable && px.label_value != '0)
         pixels_tinted++;
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop start and wait for the pipeline to empty
   task automatic settle();
      start <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register, mirror it in the shadow copy, then idle with csr_we low
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WINDOW_LEVEL:    cfg_level   = data[LEVEL_W-1:0];
         CSR_WINDOW_WIDTH:    cfg_width   = data[WIDTH_W-1:0];
         CSR_OVERLAY_ENABLE:  cfg_enable  = data[0];
         CSR_OVERLAY_OPACITY: cfg_opacity = data[OPACITY_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reset settings: window 40/400, overlay on at half opacity
   task automatic test_default_window();
      send_pixel(pixel(-32768, 0));
      send_pixel(pixel(32767, 255));
      send_pixel(pixel(-160, 0));
      send_pixel(pixel(-159, 0));
      pause(1);
      send_pixel(pixel(239, 0));
      send_pixel(pixel(240, 0));
      send_pixel(pixel(40, 1));
      settle();
   endtask

   // Widest window at the lowest level, then a zero width at the highest level
   task automatic test_window_extremes();
      write_reg(CSR_WINDOW_LEVEL, 16'h8000);
      write_reg(CSR_WINDOW_WIDTH, 16'hFFFF);
      send_pixel(pixel(32767, 0));
      send_pixel(pixel(-32768, 0));
      settle();
      // zero width acts as a width of one
      write_reg(CSR_WINDOW_LEVEL, 16'h7FFF);
      write_reg(CSR_WINDOW_WIDTH, 16'h0000);
      send_pixel(pixel(32767, 0));
      send_pixel(pixel(32766, 0));
      send_pixel(pixel(-32768, 0));
      settle();
      settings_used += 2;
   endtask

   // Overlay enable with junk upper bits, opacity extremes and saturation
   task automatic test_overlay_blend();
      write_reg(CSR_WINDOW_LEVEL, 16'h0000);
      write_reg(CSR_WINDOW_WIDTH, 16'h0002);
      write_reg(CSR_OVERLAY_ENABLE, 16'hFFFE);
      send_pixel(pixel(0, 8'hFF));
      settle();
      write_reg(CSR_OVERLAY_ENABLE, 16'h0001);
      write_reg(CSR_OVERLAY_OPACITY, 16'h0000);
      send_pixel(pixel(1, 8'h80));
      settle();
      write_reg(CSR_OVERLAY_OPACITY, 16'h0100);
      send_pixel(pixel(-1, 8'h01));
      settle();
      // opacity above full scale saturates to opaque
      write_reg(CSR_OVERLAY_OPACITY, 16'hFFFF);
      send_pixel(pixel(0, 8'h55));
      settle();
      write_reg(CSR_OVERLAY_OPACITY, 16'h0101);
      send_pixel(pixel(1, 8'hAA));
      settle();
      settings_used += 5;
   endtask

   // Pick a register setting; the first two phases pin the extremes
   task automatic program_window(input int phase);
      logic [CSR_DATA_W-1:0] lvl;
      logic [CSR_DATA_W-1:0] wid;
      logic [OPACITY_W-1:0]  opa;
      logic                  en;
      int                    r;
      en = ($urandom_range(0, 3) != 0);
      if (phase == 0) begin
         lvl = 16'h8000;
         wid = 16'h0001;
         opa = 9'd256;
         en  = 1'b1;
      end else if (phase == 1) begin
         lvl = 16'h7FFF;
         wid = 16'hFFFF;
         opa = 9'd0;
         en  = 1'b1;
      end else begin
         r = $urandom_range(0, 9);
         case (r)
            0: lvl = 16'h8000;
            1: lvl = 16'h7FFF;
            2, 3, 4: lvl = 16'($urandom_range(0, 65535));
            default: lvl = 16'($urandom_range(0, 4000) - 2000);
         endcase
         r = $urandom_range(0, 9);
         case (r)
            0: wid = 16'h0000;
            1: wid = 16'h0001;
            2: wid = 16'hFFFF;
            3, 4, 5: wid = 16'($urandom_range(2, 64));
            6, 7, 8: wid = 16'($urandom_range(65, 4000));
            default: wid = 16'($urandom_range(0, 65535));
         endcase
         r = $urandom_range(0, 9);
         case (r)
            0: opa = 9'd0;
            1: opa = 9'd256;
            2: opa = 9'($urandom_range(257, 511));
            default: opa = 9'($urandom_range(0, 256));
         endcase
      end
      write_reg(CSR_WINDOW_LEVEL, lvl);
      write_reg(CSR_WINDOW_WIDTH, wid);
      write_reg(CSR_OVERLAY_ENABLE, {15'($urandom_range(0, 32767)), en});
      write_reg(CSR_OVERLAY_OPACITY, {7'($urandom_range(0, 127)), opa});
      settings_used++;
   endtask

   // Random pixels across many settings, some phases back to back
   task automatic test_random_stream();
      int phase;
      int k;
      bit burst;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         program_window(phase);
         burst = ($urandom_range(0, 3) == 0);
         for (k = 0; k < PHASE_PIXELS; k++) begin
            send_pixel(random_pixel());
            if (!burst)
               pause(gap_cycles());
         end
      end
   endtask

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel r=%0d g=%0d b=%0d",
                   rsp_data.red, rsp_data.green, rsp_data.blue);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_data.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_data.red);
               errors++;
            end
            if (rsp_data.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_data.green);
               errors++;
            end
            if (rsp_data.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_data.blue);
               errors++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d pixels outstanding",
                  cycle_count, pending_pixels.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_default_window();
      test_window_extremes();
      test_overlay_blend();
      test_random_stream();
      settle();
      $display("tb: %0d pixels shaded and %0d compared over %0d register settings",
               pixels_sent, pixels_checked, settings_used);
      $display("tb: %0d pixels went through the overlay blend, %0d mismatches",
               pixels_tinted, errors);
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
